/* design/bds_pkg.sv */
// Shared types and constants for the broadcast duplicate suppressor.
`default_nettype none

package bds_pkg;

	localparam int unsigned ID_W    = 32;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned WIN_W   = 16;
	localparam int unsigned COUNT_W = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'hFF;
	localparam logic [COUNT_W-1:0] THRESH_RESET = 8'd3;

	// Lookup chain passed from cell to cell: first hit wins.
	typedef struct packed {
		logic found;
		logic sup;
	} chain_t;

endpackage

`default_nettype wire

/* design/bds_cell.sv */
// One table entry: compare on capture, priority chain and update on commit.
`default_nettype none

module bds_cell
	import bds_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               capture,
	input  wire logic               entry_valid,
	input  wire logic [ID_W-1:0]    message_id,
	input  wire logic [TIME_W-1:0]  now_ms,
	input  wire logic               commit,
	input  wire logic               wr_sel,
	input  wire logic [ID_W-1:0]    wr_id,
	input  wire logic [TIME_W-1:0]  wr_time,
	input  wire logic [WIN_W-1:0]   wr_window,
	input  wire logic [COUNT_W-1:0] hear_threshold,
	input  wire chain_t             chain_in,
	output chain_t                  chain_out
);

	logic [ID_W-1:0]    id_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [TIME_W-1:0]  first_q;
	logic [WIN_W-1:0]   win_q;
	logic               sup_q;
	logic               match_q;
	logic               within_q;

	logic [TIME_W-1:0]  elapsed;
	logic [COUNT_W-1:0] new_cnt;
	logic               new_sup;
	logic               hit;

	assign elapsed = now_ms - first_q;
	assign new_cnt = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_W'(1);
	assign new_sup = sup_q | (within_q && (new_cnt >= hear_threshold));
	assign hit     = match_q && !chain_in.found;

	assign chain_out.found = chain_in.found | match_q;
	assign chain_out.sup   = chain_in.found ? chain_in.sup : new_sup;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q  <= 1'b0;
			within_q <= 1'b0;
		end else if (capture) begin
			match_q  <= entry_valid && (id_q == message_id);
			within_q <= elapsed <= {{(TIME_W-WIN_W){1'b0}}, win_q};
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			if (hit) begin
				cnt_q <= new_cnt;
				sup_q <= new_sup;
			end else if (wr_sel) begin
				id_q    <= wr_id;
				cnt_q   <= COUNT_W'(1);
				first_q <= wr_time;
				win_q   <= wr_window;
				sup_q   <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* design/broadcast_duplicate_suppressor.sv */
// Top level: a row of entry cells, fill/replace control and the result register.
// The compare runs in every cell at the accepting edge and is registered there; the
// cell chain then resolves the hit and commits once the result register is free.
// A new transaction is not taken until the last one has committed (in_stall).
// Reset: fill count, replace cursor and handshake state clear, hear_threshold = 3;
// entry contents are not reset, only entries below the fill count take part.
`default_nettype none

module broadcast_duplicate_suppressor
	import bds_pkg::*;
#(
	parameter int unsigned ENTRIES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [ID_W-1:0]    message_id,
	input  wire logic [TIME_W-1:0]  now_ms,
	input  wire logic [WIN_W-1:0]   new_window_ms,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    is_new,
	output logic                    suppress,
	output logic [WIN_W-1:0]        wait_ms,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [COUNT_W-1:0] cfg_data
);

	localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned FILL_W = $clog2(ENTRIES + 1);

	logic [COUNT_W-1:0] hear_threshold_q;
	logic [FILL_W-1:0]  fill_q;
	logic [IDX_W-1:0]   cursor_q;
	logic               busy_q;
	logic               out_valid_q;
	logic               is_new_q;
	logic               suppress_q;
	logic [WIN_W-1:0]   wait_q;

	logic [ID_W-1:0]    id_s1;
	logic [TIME_W-1:0]  now_s1;
	logic [WIN_W-1:0]   win_s1;

	logic               capture;
	logic               commit;
	logic               full;
	logic               miss;
	logic [IDX_W-1:0]   slot;
	chain_t             chain [ENTRIES+1];

	assign cfg_ready = 1'b1;
	assign in_stall  = busy_q;
	assign capture   = in_valid && !busy_q;
	assign commit    = busy_q && (!out_valid_q || !out_stall);
	assign full      = (fill_q == FILL_W'(ENTRIES));
	assign slot      = full ? cursor_q : IDX_W'(fill_q);
	assign miss      = !chain[ENTRIES].found;
	assign chain[0]  = '0;

	assign out_valid = out_valid_q;
	assign is_new    = is_new_q;
	assign suppress  = suppress_q;
	assign wait_ms   = wait_q;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		bds_cell u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.capture        (capture),
			.entry_valid    (FILL_W'(i) < fill_q),
			.message_id     (message_id),
			.now_ms         (now_ms),
			.commit         (commit),
			.wr_sel         (miss && (slot == IDX_W'(i))),
			.wr_id          (id_s1),
			.wr_time        (now_s1),
			.wr_window      (win_s1),
			.hear_threshold (hear_threshold_q),
			.chain_in       (chain[i]),
			.chain_out      (chain[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			id_s1  <= message_id;
			now_s1 <= now_ms;
			win_s1 <= new_window_ms;
		end
		if (commit) begin
			is_new_q   <= miss;
			suppress_q <= chain[ENTRIES].found & chain[ENTRIES].sup;
			wait_q     <= miss ? win_s1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hear_threshold_q <= THRESH_RESET;
			fill_q           <= '0;
			cursor_q         <= '0;
			busy_q           <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				hear_threshold_q <= cfg_data;
			end
			if (capture) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				if (miss) begin
					if (!full) begin
						fill_q <= fill_q + FILL_W'(1);
					end else if (cursor_q == IDX_W'(ENTRIES - 1)) begin
						cursor_q <= '0;
					end else begin
						cursor_q <= cursor_q + IDX_W'(1);
					end
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* design/bds_checker.sv */
// Port-level checks for the broadcast duplicate suppressor, bound to the top level.
`default_nettype none

module bds_props
	import bds_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic             is_new,
	input wire logic             suppress,
	input wire logic [WIN_W-1:0] wait_ms
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a transaction is in flight");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("no result two cycles after input transaction");

	a_new_not_sup: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_new |-> !suppress)
		else $error("new id reported as suppressed");

	a_old_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_new |-> wait_ms == '0)
		else $error("known id reported with a wait time");

endmodule

bind broadcast_duplicate_suppressor bds_props u_bds_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.is_new    (is_new),
	.suppress  (suppress),
	.wait_ms   (wait_ms)
);

`default_nettype wire

/* test/bds_checker.sv */
// Checker for the broadcast duplicate suppressor: tracks the id table, predicts and compares.
module bds_checker
	import bds_pkg::*;
#(
	parameter int unsigned ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [ID_W-1:0]    message_id,
	input  logic [TIME_W-1:0]  now_ms,
	input  logic [WIN_W-1:0]   new_window_ms,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               is_new,
	input  logic               suppress,
	input  logic [WIN_W-1:0]   wait_ms,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [COUNT_W-1:0] cfg_data,
	output int unsigned        errors,
	output int unsigned        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             is_new;
		logic             suppress;
		logic [WIN_W-1:0] wait_ms;
	} verdict_t;

	logic [ID_W-1:0]    tbl_id    [ENTRIES];
	logic [COUNT_W-1:0] tbl_count [ENTRIES];
	logic [TIME_W-1:0]  tbl_first [ENTRIES];
	logic [WIN_W-1:0]   tbl_win   [ENTRIES];
	logic               tbl_sup   [ENTRIES];
	int unsigned        used;
	int unsigned        cursor;
	logic [COUNT_W-1:0] threshold;
	verdict_t           verdict_q [$];

	function automatic verdict_t hear_message(input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] t, input logic [WIN_W-1:0] win);
		verdict_t          v;
		logic [TIME_W-1:0] age;
		int                slot;
		v    = '0;
		slot = -1;
		for (int i = 0; i < used; i++)
			if (slot < 0 && tbl_id[i] == id)
				slot = i;
		if (slot >= 0) begin
			if (tbl_count[slot] != COUNT_MAX)
				tbl_count[slot]++;
			// elapsed time wraps, so a clock running backwards looks very old
			age = t - tbl_first[slot];
			if (age <= {{(TIME_W-WIN_W){1'b0}}, tbl_win[slot]} &&
					tbl_count[slot] >= threshold)
				tbl_sup[slot] = 1'b1;
			v.suppress = tbl_sup[slot];
		end else begin
			if (used < ENTRIES) begin
				slot = used;
				used++;
			end else begin
				slot   = cursor;
				cursor = (cursor + 1) % ENTRIES;
			end
			tbl_id[slot]    = id;
			tbl_count[slot] = COUNT_W'(1);
			tbl_first[slot] = t;
			tbl_win[slot]   = win;
			tbl_sup[slot]   = 1'b0;
			v.is_new  = 1'b1;
			v.wait_ms = win;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			used      = 0;
			cursor    = 0;
			threshold = THRESH_RESET;
			verdict_q.delete();
			errors    = 0;
			pending   = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected result, expected none, %s %0b %0b %0d",
						$time, "got is_new suppress wait_ms", is_new, suppress,
						wait_ms);
				end else begin
					want = verdict_q.pop_front();
					if (is_new !== want.is_new) begin
						errors++;
						$display("%0t ns: is_new expected %0b got %0b", $time,
							want.is_new, is_new);
					end
					if (suppress !== want.suppress) begin
						errors++;
						$display("%0t ns: suppress expected %0b got %0b", $time,
							want.suppress, suppress);
					end
					if (wait_ms !== want.wait_ms) begin
						errors++;
						$display("%0t ns: wait_ms expected %0d got %0d", $time,
							want.wait_ms, wait_ms);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				threshold = cfg_data;
			if (in_valid && !in_stall)
				verdict_q.push_back(hear_message(message_id, now_ms, new_window_ms));
			pending = verdict_q.size();
		end
	end

endmodule

/* test/tb_broadcast_duplicate_suppressor.sv */
// Testbench top for the broadcast duplicate suppressor: stimulus, idling and verdict.
module tb_broadcast_duplicate_suppressor
	import bds_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RECENT = 32;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [ID_W-1:0]    message_id;
	logic [TIME_W-1:0]  now_ms;
	logic [WIN_W-1:0]   new_window_ms;
	logic               out_valid;
	logic               out_stall;
	logic               is_new;
	logic               suppress;
	logic [WIN_W-1:0]   wait_ms;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [COUNT_W-1:0] cfg_data;
	int unsigned        errors;
	int unsigned        pending;

	bit                quiet_tx = 1'b0;
	bit                quiet_rx = 1'b0;
	logic [ID_W-1:0]   recent [RECENT];
	int unsigned       recent_n = 0;
	int unsigned       recent_head = 0;
	logic [TIME_W-1:0] clock_ms;

	broadcast_duplicate_suppressor i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.message_id    (message_id),
		.now_ms        (now_ms),
		.new_window_ms (new_window_ms),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.is_new        (is_new),
		.suppress      (suppress),
		.wait_ms       (wait_ms),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	bds_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.message_id    (message_id),
		.now_ms        (now_ms),
		.new_window_ms (new_window_ms),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.is_new        (is_new),
		.suppress      (suppress),
		.wait_ms       (wait_ms),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int unsigned hold;
		hold      = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold != 0)
				hold--;
			else if (!quiet_rx && $urandom_range(0, 3) == 0)
				hold = idle_len();
			out_stall <= (hold != 0);
		end
	end

	task automatic push_item(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] t,
			input logic [WIN_W-1:0] win);
		int unsigned gap;
		@(negedge clk);
		in_valid      <= 1'b1;
		message_id    <= id;
		now_ms        <= t;
		new_window_ms <= win;
		do @(posedge clk); while (in_stall);
		recent[recent_head] = id;
		recent_head = (recent_head + 1) % RECENT;
		if (recent_n < RECENT)
			recent_n++;
		gap = quiet_tx ? 0 : idle_len();
		if (gap != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// hold off until every outstanding transaction has produced its result
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic set_threshold(input logic [COUNT_W-1:0] thr);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= thr;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drive one id past 255 hears outside its window, then hear it inside
	task automatic hammer();
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] t0;
		logic [WIN_W-1:0]  win;
		id  = $urandom();
		t0  = $urandom();
		win = WIN_W'($urandom_range(0, 65535));
		push_item(id, t0, win);
		repeat (270) push_item(id, t0 - TIME_W'($urandom_range(1, 5000)), win);
		repeat (10) push_item(id, t0 + TIME_W'($urandom_range(0, win)), win);
	endtask

	task automatic random_item();
		logic [ID_W-1:0]  id;
		logic [WIN_W-1:0] win;
		int unsigned      r;
		int unsigned      span;
		r = $urandom_range(0, 99);
		if (r < 45 && recent_n != 0) begin
			span = recent_n < 6 ? recent_n : 6;
			id   = recent[(recent_head + RECENT - 1 - $urandom_range(0, span - 1)) % RECENT];
		end else if (r < 70 && recent_n != 0) begin
			id = recent[(recent_head + RECENT - 1 - $urandom_range(0, recent_n - 1)) % RECENT];
		end else if (r < 78) begin
			case ($urandom_range(0, 3))
				0: id = '0;
				1: id = '1;
				2: id = 32'h1 << $urandom_range(0, 31);
				default: id = ~(32'h1 << $urandom_range(0, 31));
			endcase
		end else begin
			id = $urandom();
		end
		r = $urandom_range(0, 99);
		if (r < 70)
			clock_ms += $urandom_range(0, 40);
		else if (r < 85)
			clock_ms += $urandom_range(0, 3000);
		else if (r < 92)
			clock_ms -= $urandom_range(1, 500);
		else if (r < 97)
			clock_ms += $urandom_range(20000, 70000);
		else
			clock_ms = $urandom();
		r = $urandom_range(0, 99);
		if (r < 10)
			win = '0;
		else if (r < 20)
			win = '1;
		else if (r < 75)
			win = WIN_W'($urandom_range(1, 600));
		else
			win = WIN_W'($urandom_range(0, 65535));
		push_item(id, clock_ms, win);
	endtask

	initial begin
		logic [COUNT_W-1:0] thr;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		message_id    = '0;
		now_ms        = '0;
		new_window_ms = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		clock_ms      = $urandom();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset threshold of 3: reach it, sticky flag, wrapping and backwards time
		push_item(32'h0000_0000, 32'h0000_0000, 16'h0000);
		push_item(32'h0000_0000, 32'h0000_0000, 16'h0000);
		push_item(32'h0000_0000, 32'h0000_0000, 16'h0000);
		push_item(32'h0000_0000, 32'h0000_03E8, 16'h0000);
		push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		push_item(32'hFFFF_FFFF, 32'h0000_FFFE, 16'hFFFF);
		push_item(32'hFFFF_FFFF, 32'h0000_FFFE, 16'hFFFF);
		push_item(32'hFFFF_FFFF, 32'h0000_FFFF, 16'h0000);
		push_item(32'h0000_0005, 32'h0000_0064, 16'h000A);
		push_item(32'h0000_0005, 32'h0000_0063, 16'h000A);
		push_item(32'h0000_0005, 32'h0000_0063, 16'h000A);
		push_item(32'h0000_0005, 32'h0000_006E, 16'h000A);
		push_item(32'h0000_0006, 32'h0000_006E, 16'h000A);
		push_item(32'h0000_0006, 32'h0000_0079, 16'h000A);
		push_item(32'h0000_0006, 32'h0000_0079, 16'h000A);

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: thr = 8'd1;
				1: thr = 8'd2;
				2: thr = COUNT_MAX;
				3: thr = 8'd0;
				4: thr = COUNT_W'($urandom_range(3, 8));
				5: thr = 8'd254;
				6: thr = COUNT_W'($urandom_range(1, 255));
				default: thr = COUNT_W'($urandom_range(2, 6));
			endcase
			set_threshold(thr);
			if (thr == COUNT_MAX)
				hammer();
			for (int n = 0; n < 250; n++) begin
				if (n % 100 == 0) begin
					quiet_tx = ($urandom_range(0, 3) == 0);
					quiet_rx = ($urandom_range(0, 3) == 0);
				end
				if ($urandom_range(0, 99) == 0)
					drain();
				random_item();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
design/bds_pkg.sv
design/bds_cell.sv
design/broadcast_duplicate_suppressor.sv
design/bds_checker.sv
test/bds_checker.sv
test/tb_broadcast_duplicate_suppressor.sv
